// File: rtl/tsd_pkg.sv
// Shared types, action codes and fixed-point constants for the three-axis servo smoothing damper.
// No dependencies; every other file in rtl except tsd_div refers to this package by scoped names.
package tsd_pkg;

    typedef enum logic [1:0] {
        ACT_TICK    = 2'd0,
        ACT_HOLD    = 2'd1,
        ACT_JUMP    = 2'd2,
        ACT_REFRESH = 2'd3
    } act_t;

    localparam logic [15:0] ANG_MAX     = 16'd46080;
    localparam logic [15:0] ANG_MIN_LIM = 16'd7680;
    localparam logic [15:0] ANG_RESET   = 16'd23040;

    localparam logic signed [16:0] VEL_MAX = 17'h0FFFF;
    localparam logic signed [16:0] VEL_MIN = 17'h10000;

    // Pulse = 500 + floor((25 * angle + 288) / 576), with the division by 576 done as a shift
    // by six and a multiplication by the reciprocal of nine, ceil(2^19 / 9).
    localparam logic [11:0] PULSE_BASE  = 12'd500;
    localparam logic [4:0]  PULSE_GAIN  = 5'd25;
    localparam logic [20:0] PULSE_OFS   = 21'd288;
    localparam logic [15:0] PULSE_RECIP = 16'd58255;

    // Change limit = floor((max_speed * T * 32 + 62) / 125), the division done with
    // the reciprocal ceil(2^29 / 125).
    localparam logic [22:0] MC_RECIP = 23'd4294968;

    // Per-tick coefficients shared by all lanes.
    typedef struct packed {
        logic [9:0]  t;
        logic [16:0] e;
        logic [15:0] mc;
    } coef_t;

    typedef struct packed {
        logic        start;
        act_t        act;
        logic [15:0] tgt;
    } lane_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] angle;
        logic [11:0] pulse;
        logic        changed;
    } lane_res_t;

    function automatic logic [15:0] clamp_tgt(input logic [15:0] raw, input logic [15:0] lo);
        logic [15:0] r;
        r = raw;
        if (r < lo) begin
            r = lo;
        end
        if (r > ANG_MAX) begin
            r = ANG_MAX;
        end
        return r;
    endfunction

endpackage

// File: rtl/tsd_div.sv
// Restoring unsigned divider, one quotient bit per clock.
// Depends on nothing; used by the coefficient unit and by each lane.
module tsd_div #(
    parameter int NW = 37,
    parameter int DW = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] quot_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg, quot_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                quot_reg <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= CW'(NW);
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                if (fits) begin
                    rem_reg <= DW'(trial - {1'b0, den_reg});
                end else begin
                    rem_reg <= trial[DW-1:0];
                end
                quot_reg <= {quot_reg[NW-2:0], fits};
                cnt_reg  <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// File: rtl/tsd_coef.sv
// Per-tick coefficient unit: decay factor e (Q1.16) and change limit mc (Q8.8).
// Depends on tsd_pkg and tsd_div.
module tsd_coef #(
    parameter int TICK_MS = 20
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [9:0]    smooth_time_ms,
    input  logic [6:0]    max_speed,
    output logic          done,
    output tsd_pkg::coef_t coef
);

    localparam logic [37:0] K1 = 38'(200 * TICK_MS);
    localparam logic [37:0] K2 = 38'(192 * TICK_MS * TICK_MS);
    localparam logic [37:0] K3 = 38'(188 * TICK_MS * TICK_MS * TICK_MS);

    typedef enum logic [3:0] {
        C_IDLE, C_T2, C_T3, C_NUM, C_DEN, C_EGO, C_EWAIT
    } cstate_t;

    cstate_t     state_reg;
    logic [9:0]  t_reg;
    logic [19:0] t2_reg;
    logic [29:0] t3_reg;
    logic [36:0] num_reg;
    logic [37:0] part_reg;
    logic [37:0] den_reg;
    logic [16:0] mst_reg;
    logic [16:0] e_reg;
    logic [15:0] mc_reg;
    logic        done_reg;

    logic        div_start;
    logic [53:0] div_num;
    logic [37:0] div_den;
    logic        div_done;
    logic [53:0] div_quot;

    // Change limit: (mst * 256 + 500) / 1000 equals (mst * 32 + 62) / 125 after flooring.
    logic [21:0] mc_y;
    logic [44:0] mc_prod;
    assign mc_y    = {mst_reg, 5'b0} + 22'd62;
    assign mc_prod = 45'(mc_y) * 45'(tsd_pkg::MC_RECIP);

    assign div_start = (state_reg == C_EGO);
    assign div_num   = 54'({num_reg, 16'b0}) + 54'(den_reg >> 1);
    assign div_den   = den_reg;

    tsd_div #(.NW(54), .DW(38)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        t_reg     <= (smooth_time_ms == 10'd0) ? 10'd1 : smooth_time_ms;
                        state_reg <= C_T2;
                    end
                end
                C_T2: begin
                    t2_reg    <= 20'(t_reg) * 20'(t_reg);
                    state_reg <= C_T3;
                end
                C_T3: begin
                    t3_reg    <= 30'(t2_reg) * 30'(t_reg);
                    state_reg <= C_NUM;
                end
                C_NUM: begin
                    num_reg   <= 37'(t3_reg) * 37'd100;
                    part_reg  <= 38'(t2_reg) * K1;
                    state_reg <= C_DEN;
                end
                C_DEN: begin
                    den_reg   <= 38'(num_reg) + part_reg + 38'(t_reg) * K2 + K3;
                    mst_reg   <= 17'(max_speed) * 17'(t_reg);
                    state_reg <= C_EGO;
                end
                C_EGO: begin
                    mc_reg    <= mc_prod[44:29];
                    state_reg <= C_EWAIT;
                end
                C_EWAIT: begin
                    if (div_done) begin
                        e_reg     <= div_quot[16:0];
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                end
                default: begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign coef.t  = t_reg;
    assign coef.e  = e_reg;
    assign coef.mc = mc_reg;

endmodule

// File: rtl/tsd_lane.sv
// One servo axis: holds angle, velocity and last pulse, runs the damping step and pulse conversion.
// Depends on tsd_pkg and tsd_div.
module tsd_lane #(
    parameter int TICK_MS = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tsd_pkg::lane_req_t req,
    input  tsd_pkg::coef_t     coef,
    output tsd_pkg::lane_res_t res
);

    localparam logic signed [36:0] K_D   = 37'(TICK_MS);
    localparam logic signed [36:0] K_CHG = 37'(2000 * TICK_MS);

    typedef enum logic [3:0] {
        L_IDLE, L_VT, L_TNUM, L_TGO, L_TWAIT, L_AB, L_PN, L_PO,
        L_NGO, L_NWAIT, L_FIX, L_PGO, L_PWAIT
    } lstate_t;

    lstate_t            state_reg;
    logic [15:0]        angle_reg;
    logic signed [16:0] vel_reg;
    logic [11:0]        lastp_reg;
    logic [15:0]        tgt_reg;
    logic signed [16:0] change_reg;
    logic signed [18:0] tgt2_reg;
    logic signed [27:0] vt_reg;
    logic signed [36:0] tnum_reg;
    logic signed [16:0] temp_reg;
    logic signed [29:0] a_reg;
    logic signed [17:0] b_reg;
    logic signed [47:0] pn_reg;
    logic signed [34:0] po_reg;
    logic signed [18:0] out_reg;
    logic signed [31:0] nv_reg;
    logic [14:0]        pw_reg;
    logic [11:0]        pulse_reg;
    logic               changed_reg;
    logic               done_reg;

    // Clamp of the distance to the target against the change limit.
    logic signed [16:0] diff;
    logic signed [16:0] mc_s;
    logic signed [16:0] change_c;
    assign diff = $signed({1'b0, angle_reg}) - $signed({1'b0, req.tgt});
    assign mc_s = $signed({1'b0, coef.mc});
    always_comb begin
        change_c = diff;
        if (diff > mc_s) begin
            change_c = mc_s;
        end else if (diff < -mc_s) begin
            change_c = -mc_s;
        end
    end

    // Sign- and zero-extended operands.
    logic signed [27:0] vel_x28;
    logic signed [27:0] t_x28;
    logic signed [36:0] vt_x37;
    logic signed [36:0] chg_x37;
    logic signed [29:0] vt_x30;
    logic signed [29:0] temp_x30;
    logic signed [17:0] chg_x18;
    logic signed [17:0] temp_x18;
    logic signed [47:0] a_x48;
    logic signed [47:0] e_x48;
    logic signed [34:0] b_x35;
    logic signed [34:0] e_x35;
    assign vel_x28  = 28'(vel_reg);
    assign t_x28    = $signed(28'(coef.t));
    assign vt_x37   = 37'(vt_reg);
    assign chg_x37  = 37'(change_reg);
    assign vt_x30   = 30'(vt_reg);
    assign temp_x30 = 30'(temp_reg);
    assign chg_x18  = 18'(change_reg);
    assign temp_x18 = 18'(temp_reg);
    assign a_x48    = 48'(a_reg);
    assign e_x48    = $signed(48'(coef.e));
    assign b_x35    = 35'(b_reg);
    assign e_x35    = $signed(35'(coef.e));

    // Magnitudes with the half-divisor added for round-half-away-from-zero.
    logic [36:0] tmag;
    logic [47:0] pmag;
    logic [34:0] omag;
    logic [18:0] oround;
    assign tmag   = (tnum_reg[36] ? 37'(-tnum_reg) : 37'(tnum_reg)) + 37'(coef.t) * 37'd500;
    assign pmag   = (pn_reg[47] ? 48'(-pn_reg) : 48'(pn_reg)) + (48'(coef.t) << 15);
    assign omag   = (po_reg[34] ? 35'(-po_reg) : 35'(po_reg)) + 35'd32768;
    assign oround = omag[34:16];

    logic        div_start;
    logic [36:0] div_num;
    logic [19:0] div_den;
    logic        div_done;
    logic [36:0] div_quot;

    always_comb begin
        div_start = 1'b0;
        div_num   = tmag;
        div_den   = 20'(coef.t) * 20'd1000;
        unique case (state_reg)
            L_TGO: begin
                div_start = 1'b1;
            end
            L_NGO: begin
                div_start = 1'b1;
                div_num   = 37'(pmag[47:16]);
                div_den   = 20'(coef.t);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tsd_div #(.NW(37), .DW(20)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // Pulse stage: the scaled angle is shifted down by six, then divided by nine.
    logic [20:0] pz;
    logic [30:0] pprod;
    logic [11:0] pulse_new;
    assign pz        = 21'(angle_reg) * 21'(tsd_pkg::PULSE_GAIN) + tsd_pkg::PULSE_OFS;
    assign pprod     = 31'(pw_reg) * 31'(tsd_pkg::PULSE_RECIP);
    assign pulse_new = tsd_pkg::PULSE_BASE + pprod[30:19];

    logic up;
    logic over;
    assign up   = tgt_reg > angle_reg;
    assign over = out_reg > $signed({3'b0, tgt_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            angle_reg <= tsd_pkg::ANG_RESET;
            vel_reg   <= '0;
            lastp_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (req.start) begin
                        tgt_reg <= req.tgt;
                        unique case (req.act)
                            tsd_pkg::ACT_TICK: begin
                                change_reg <= change_c;
                                tgt2_reg   <= 19'(angle_reg) - 19'(change_c);
                                state_reg  <= L_VT;
                            end
                            tsd_pkg::ACT_HOLD: begin
                                vel_reg   <= '0;
                                state_reg <= L_PGO;
                            end
                            tsd_pkg::ACT_JUMP: begin
                                angle_reg <= req.tgt;
                                vel_reg   <= '0;
                                state_reg <= L_PGO;
                            end
                            tsd_pkg::ACT_REFRESH: begin
                                state_reg <= L_PGO;
                            end
                            default: begin
                                state_reg <= L_PGO;
                            end
                        endcase
                    end
                end
                L_VT: begin
                    vt_reg    <= vel_x28 * t_x28;
                    state_reg <= L_TNUM;
                end
                L_TNUM: begin
                    tnum_reg  <= vt_x37 * K_D + chg_x37 * K_CHG;
                    state_reg <= L_TGO;
                end
                L_TGO: begin
                    state_reg <= L_TWAIT;
                end
                L_TWAIT: begin
                    if (div_done) begin
                        temp_reg  <= tnum_reg[36] ? -$signed(17'(div_quot))
                                                  : $signed(17'(div_quot));
                        state_reg <= L_AB;
                    end
                end
                L_AB: begin
                    a_reg     <= vt_x30 - temp_x30 * 30'sd2000;
                    b_reg     <= chg_x18 + temp_x18;
                    state_reg <= L_PN;
                end
                L_PN: begin
                    pn_reg    <= a_x48 * e_x48;
                    state_reg <= L_PO;
                end
                L_PO: begin
                    po_reg    <= b_x35 * e_x35;
                    state_reg <= L_NGO;
                end
                L_NGO: begin
                    out_reg   <= po_reg[34] ? tgt2_reg - $signed(oround)
                                            : tgt2_reg + $signed(oround);
                    state_reg <= L_NWAIT;
                end
                L_NWAIT: begin
                    if (div_done) begin
                        nv_reg    <= pn_reg[47] ? -$signed(32'(div_quot))
                                                : $signed(32'(div_quot));
                        state_reg <= L_FIX;
                    end
                end
                L_FIX: begin
                    if (up == over) begin
                        angle_reg <= tgt_reg;
                        vel_reg   <= '0;
                    end else begin
                        if (out_reg < 19'sd0) begin
                            angle_reg <= '0;
                        end else if (out_reg > $signed({3'b0, tsd_pkg::ANG_MAX})) begin
                            angle_reg <= tsd_pkg::ANG_MAX;
                        end else begin
                            angle_reg <= out_reg[15:0];
                        end
                        if (nv_reg > 32'(tsd_pkg::VEL_MAX)) begin
                            vel_reg <= tsd_pkg::VEL_MAX;
                        end else if (nv_reg < 32'(tsd_pkg::VEL_MIN)) begin
                            vel_reg <= tsd_pkg::VEL_MIN;
                        end else begin
                            vel_reg <= nv_reg[16:0];
                        end
                    end
                    state_reg <= L_PGO;
                end
                L_PGO: begin
                    pw_reg    <= pz[20:6];
                    state_reg <= L_PWAIT;
                end
                L_PWAIT: begin
                    pulse_reg   <= pulse_new;
                    changed_reg <= pulse_new != lastp_reg;
                    lastp_reg   <= pulse_new;
                    done_reg    <= 1'b1;
                    state_reg   <= L_IDLE;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

    assign res.done    = done_reg;
    assign res.angle   = angle_reg;
    assign res.pulse   = pulse_reg;
    assign res.changed = changed_reg;

endmodule

// File: rtl/three_axis_servo_smooth_damper_top.sv
// Top level of the three-axis servo smoothing damper: stream ports, registers, lanes, merge.
// Depends on tsd_pkg, tsd_coef, tsd_lane (and through them tsd_div).

// One input word carries an action and three targets; one output word carries the three angles,
// their servo pulse widths and a mask of pulses that changed since the last word sent. A tick
// first runs the coefficient unit, whose serial divider forms the decay factor (54 quotient bits)
// while the change limit comes from a reciprocal multiplication; the three axis lanes then work
// side by side, each passing two divisions of 37 bits through its own serial divider before
// the pulse stage. Hold, jump and refresh only run the pulse stage. One word is in flight at a
// time: s_tready is high while the block waits for a word, and the finished word sits in an
// output register, so a new word may be taken while the previous result still waits on
// m_tready. Configuration writes are taken at any clock and should only be issued while idle.
module three_axis_servo_smooth_damper_top #(
    parameter int TICK_MS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // az_target[15:0], incline_target[31:16], progress_target[47:32]
    input  logic [1:0]  s_tuser,   // action[1:0]
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // az_angle[15:0], incline_angle[31:16], progress_angle[47:32], az_pulse[59:48],
    // incline_pulse[71:60], progress_pulse[83:72], pulse_changed[86:84], zero pad [87]
    output logic [87:0] m_tdata,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_wdata
);

    localparam logic CFG_SMOOTH = 1'b0;
    localparam logic CFG_SPEED  = 1'b1;

    typedef enum logic [2:0] {
        T_IDLE, T_CGO, T_CWAIT, T_LGO, T_LWAIT, T_OUT
    } tstate_t;

    tstate_t             state_reg;
    logic [9:0]          smooth_reg;
    logic [6:0]          speed_reg;
    tsd_pkg::act_t       act_reg;
    logic [15:0]         tgt_reg [3];
    logic [2:0]          seen_reg;
    logic                m_tvalid_reg;
    logic [87:0]         m_tdata_reg;

    tsd_pkg::coef_t      coef;
    logic                coef_done;
    tsd_pkg::lane_req_t  req  [3];
    tsd_pkg::lane_res_t  res  [3];
    logic [2:0]          lane_done;
    logic                accept;

    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= 10'd350;
            speed_reg  <= 7'd12;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SMOOTH: smooth_reg <= cfg_wdata;
                CFG_SPEED:  speed_reg  <= cfg_wdata[6:0];
                default:    smooth_reg <= smooth_reg;
            endcase
        end
    end

    tsd_coef #(.TICK_MS(TICK_MS)) u_coef (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (state_reg == T_CGO),
        .smooth_time_ms (smooth_reg),
        .max_speed      (speed_reg),
        .done           (coef_done),
        .coef           (coef)
    );

    // Three identical lanes, one per axis. Azimuth may go down to zero; the other two stop at
    // thirty degrees.
    for (genvar i = 0; i < 3; i++) begin : g_lane
        assign req[i].start = (state_reg == T_LGO);
        assign req[i].act   = act_reg;
        assign req[i].tgt   = tgt_reg[i];
        assign lane_done[i] = res[i].done;

        always_ff @(posedge aclk) begin
            if (accept) begin
                tgt_reg[i] <= tsd_pkg::clamp_tgt(s_tdata[16*i +: 16],
                                                 (i == 0) ? 16'd0 : tsd_pkg::ANG_MIN_LIM);
            end
        end

        tsd_lane #(.TICK_MS(TICK_MS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .req     (req[i]),
            .coef    (coef),
            .res     (res[i])
        );
    end

    // Sequencer and merge stage: the three lane results are packed into the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= T_IDLE;
            m_tvalid_reg <= 1'b0;
            seen_reg     <= '0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        act_reg   <= tsd_pkg::act_t'(s_tuser);
                        state_reg <= (tsd_pkg::act_t'(s_tuser) == tsd_pkg::ACT_TICK)
                                     ? T_CGO : T_LGO;
                    end
                end
                T_CGO: begin
                    state_reg <= T_CWAIT;
                end
                T_CWAIT: begin
                    if (coef_done) begin
                        state_reg <= T_LGO;
                    end
                end
                T_LGO: begin
                    seen_reg  <= '0;
                    state_reg <= T_LWAIT;
                end
                T_LWAIT: begin
                    seen_reg <= seen_reg | lane_done;
                    if ((seen_reg | lane_done) == 3'b111) begin
                        state_reg <= T_OUT;
                    end
                end
                T_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {1'b0,
                                         res[2].changed, res[1].changed, res[0].changed,
                                         res[2].pulse, res[1].pulse, res[0].pulse,
                                         res[2].angle, res[1].angle, res[0].angle};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the three-axis servo smoothing damper.
// Needs rtl/tsd_pkg.sv and the block's RTL under three_axis_servo_smooth_damper_top.
`timescale 1ns / 100ps

module tb_top;

    localparam int  TICK_MS    = 20;
    localparam int  SETTLE     = 300;
    localparam int  LIMIT      = 4000000;
    localparam int  HOLD_LEN   = 3000;
    localparam logic REG_SMOOTH = 1'b0;
    localparam logic REG_SPEED  = 1'b1;

    // One result word as the block packs it, lowest field last.
    typedef struct packed {
        logic [2:0]       chg;
        logic [2:0][11:0] pul;
        logic [2:0][15:0] ang;
    } pose_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [9:0]  cfg_wdata = '0;

    // Predictor state: registers, angles, velocities and the pulses last sent.
    logic [9:0]  smooth_ms;
    logic [6:0]  speed_lim;
    longint      angle_q[3];
    longint      vel_q[3];
    longint      sent_pulse[3];

    pose_t       pose_q[$];
    int          n_errors = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          hold_req = 0;
    int          hold_cnt = 0;
    longint      cycle_cnt = 0;

    three_axis_servo_smooth_damper_top #(.TICK_MS(TICK_MS)) dut (.*);

    always #6 aclk = ~aclk;

    // Runaway guard.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    // Rounded division, halves away from zero.
    function automatic longint rdiv(input longint n, input longint d);
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clip(input longint x, input longint lo, input longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // Works out the word the block should produce for one accepted input and
    // advances the predictor state accordingly.
    task automatic predict_pose(input tsd_pkg::act_t act, input logic [47:0] tg_raw);
        longint tg[3];
        longint t, d, num, den, e, mc, cur, v, chg, tmp, nv, nxt, p;
        pose_t  r;
        d = TICK_MS;
        r = '0;
        for (int i = 0; i < 3; i++)
            tg[i] = clip(longint'(tg_raw[16*i +: 16]), i == 0 ? 0 : 7680, 46080);
        case (act)
            tsd_pkg::ACT_TICK: begin
                t = (smooth_ms == 0) ? 1 : longint'(smooth_ms);
                num = 100 * t * t * t;
                den = num + 200 * d * t * t + 192 * d * d * t + 188 * d * d * d;
                e = ((num <<< 16) + den / 2) / den;
                mc = (longint'(speed_lim) * t * 256 + 500) / 1000;
                for (int i = 0; i < 3; i++) begin
                    cur = angle_q[i];
                    v = vel_q[i];
                    chg = clip(cur - tg[i], -mc, mc);
                    tmp = rdiv(v * d * t + chg * 2000 * d, 1000 * t);
                    nv = rdiv((v * t - 2000 * tmp) * e, t * 65536);
                    nxt = (cur - chg) + rdiv((chg + tmp) * e, 65536);
                    // A step that would cross the target snaps onto it.
                    if ((tg[i] - cur > 0) == (nxt > tg[i])) begin
                        nxt = tg[i];
                        nv = 0;
                    end
                    angle_q[i] = clip(nxt, 0, 46080);
                    vel_q[i] = clip(nv, -65536, 65535);
                end
            end
            tsd_pkg::ACT_HOLD: for (int i = 0; i < 3; i++) vel_q[i] = 0;
            tsd_pkg::ACT_JUMP: for (int i = 0; i < 3; i++) begin
                angle_q[i] = tg[i];
                vel_q[i] = 0;
            end
            default: ;
        endcase
        for (int i = 0; i < 3; i++) begin
            p = 500 + (angle_q[i] * 2000 + 23040) / 46080;
            if (p != sent_pulse[i]) begin
                r.chg[i] = 1'b1;
                sent_pulse[i] = p;
            end
            r.ang[i] = angle_q[i][15:0];
            r.pul[i] = p[11:0];
        end
        pose_q.push_back(r);
    endtask

    // Offers one word and waits for the block to take it. s_tvalid stays high
    // into the next call unless that call inserts an idle gap first.
    task automatic send_word(input tsd_pkg::act_t act, input logic [15:0] az,
                             input logic [15:0] inc, input logic [15:0] prg);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {prg, inc, az};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pose(act, {prg, inc, az});
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic set_regs(input logic [9:0] t_ms, input logic [6:0] spd);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= REG_SMOOTH;
        cfg_wdata <= t_ms;
        @(posedge aclk);
        cfg_index <= REG_SPEED;
        cfg_wdata <= {3'b000, spd};
        @(posedge aclk);
        cfg_we <= 1'b0;
        smooth_ms = t_ms;
        speed_lim = spd;
    endtask

    // A requested hold-off is counted down in cycles here.
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_cnt <= HOLD_LEN;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result checker: each word taken is compared with the oldest prediction.
    always @(posedge aclk) begin
        pose_t got, exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[86:0];
            if (pose_q.size() == 0) begin
                report("result word with nothing predicted");
            end else begin
                exp_w = pose_q.pop_front();
                for (int i = 0; i < 3; i++) begin
                    if (got.ang[i] !== exp_w.ang[i])
                        report($sformatf("axis %0d angle %0d, predicted %0d",
                                         i, got.ang[i], exp_w.ang[i]));
                    if (got.pul[i] !== exp_w.pul[i])
                        report($sformatf("axis %0d pulse %0d, predicted %0d",
                                         i, got.pul[i], exp_w.pul[i]));
                end
                if (got.chg !== exp_w.chg)
                    report($sformatf("changed mask %b, predicted %b", got.chg, exp_w.chg));
                if (m_tdata[87] !== 1'b0)
                    report("pad bit set in result word");
            end
        end
        // While a hold-off runs, m_tready stays low.
        if (hold_cnt > 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [15:0] any_target();
        case ($urandom_range(3))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(46080));
            2: return 16'($urandom_range(7000, 8400));
            default: return 16'($urandom_range(45000, 47000));
        endcase
    endfunction

    // Pulses straight after reset must all be flagged as new.
    task automatic test_after_reset;
        send_word(tsd_pkg::ACT_REFRESH, 16'hFFFF, 16'h0000, 16'h1234);
        send_word(tsd_pkg::ACT_REFRESH, 16'h0000, 16'hFFFF, 16'h0000);
    endtask

    // Target extremes, every action, the overshoot snap and target equal to angle.
    task automatic test_directed;
        send_word(tsd_pkg::ACT_JUMP, 16'h0000, 16'h0000, 16'h0000);
        send_word(tsd_pkg::ACT_JUMP, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(tsd_pkg::ACT_JUMP, 16'd46081, 16'd7679, 16'd7680);
        send_word(tsd_pkg::ACT_JUMP, 16'd46080, 16'd46080, 16'd46080);
        repeat (4) send_word(tsd_pkg::ACT_TICK, 16'd0, 16'd0, 16'd0);
        send_word(tsd_pkg::ACT_HOLD, 16'hAAAA, 16'h5555, 16'hFFFF);
        repeat (3) send_word(tsd_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(tsd_pkg::ACT_JUMP, 16'd23040, 16'd23040, 16'd23040);
        send_word(tsd_pkg::ACT_TICK, 16'd23040, 16'd23040, 16'd23040);
        send_word(tsd_pkg::ACT_TICK, 16'd23041, 16'd23039, 16'd23040);
        send_word(tsd_pkg::ACT_REFRESH, 16'd0, 16'd0, 16'd0);
        set_regs(10'd1, 7'd90);
        send_word(tsd_pkg::ACT_JUMP, 16'd0, 16'd7680, 16'd46080);
        repeat (3) send_word(tsd_pkg::ACT_TICK, 16'd46080, 16'd46080, 16'd7680);
        set_regs(10'd1000, 7'd0);
        repeat (2) send_word(tsd_pkg::ACT_TICK, 16'd0, 16'd46080, 16'd46080);
    endtask

    // Mostly runs of ticks that chase a fixed set of targets, with the
    // occasional hold, jump, refresh and ticks with scattered targets.
    task automatic test_random(input int n_words);
        logic [15:0] a, b, c;
        int sent, run;
        sent = 0;
        while (sent < n_words) begin
            a = any_target();
            b = any_target();
            c = any_target();
            if ($urandom_range(3) == 0) begin
                send_word(tsd_pkg::ACT_JUMP, any_target(), any_target(), any_target());
                sent++;
            end
            run = $urandom_range(3, 25);
            for (int k = 0; k < run && sent < n_words; k++) begin
                case ($urandom_range(19))
                    0: send_word(tsd_pkg::ACT_HOLD, any_target(), any_target(), any_target());
                    1: send_word(tsd_pkg::ACT_REFRESH, any_target(), any_target(),
                                 any_target());
                    2: send_word(tsd_pkg::ACT_TICK, any_target(), any_target(), any_target());
                    default: send_word(tsd_pkg::ACT_TICK, a, b, c);
                endcase
                sent++;
            end
        end
    endtask

    // The receiver holds off while words keep coming, so the block fills up.
    task automatic test_backpressure;
        hold_req = 1;
        for (int k = 0; k < 20; k++) begin
            if (k % 3 == 0)
                send_word(tsd_pkg::ACT_JUMP, any_target(), any_target(), any_target());
            else
                send_word(tsd_pkg::ACT_TICK, any_target(), any_target(), any_target());
        end
    endtask

    initial begin
        smooth_ms = 10'd350;
        speed_lim = 7'd12;
        for (int i = 0; i < 3; i++) begin
            angle_q[i] = 23040;
            vel_q[i] = 0;
            sent_pulse[i] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_directed();

        // Sender rarely idles, receiver mostly stalls.
        tx_idle_pct = 9;
        rx_stall_pct = 83;
        set_regs(10'd350, 7'd12);
        test_random(250);
        set_regs(10'd0, 7'd127);
        test_random(200);

        // And the other way round.
        tx_idle_pct = 83;
        rx_stall_pct = 9;
        set_regs(10'd1023, 7'd1);
        test_random(200);
        set_regs(10'($urandom_range(1, 1000)), 7'($urandom_range(1, 90)));
        test_random(250);

        // Neither side idles at random; the backpressure test holds the receiver off.
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        set_regs(10'd50, 7'd90);
        test_backpressure();
        set_regs(10'($urandom_range(1, 1023)), 7'($urandom_range(0, 127)));
        test_random(250);
        set_regs(10'd5, 7'd45);
        test_random(250);

        drain();
        if (n_errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
